// ===== rtl/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants for the greedy box suppression unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbs_pkg;

  localparam int MAX_BOXES_DEF  = 64;
  localparam int COORD_BITS_DEF = 12;
  localparam int SCORE_BITS_DEF = 16;

  localparam int CLASS_BITS  = 8;
  localparam int THRESH_BITS = 16;
  localparam int FRAC_BITS   = 16;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd29491;

endpackage

`default_nettype wire

// ===== rtl/greedy_box_suppression_unit.sv =====
// ----------------------------------------------------------------------------
// greedy_box_suppression_unit
// Class-agnostic greedy IoU suppression over a set of scored boxes.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  box_*, last_box
//   out      output     out_valid/out_stall kept_*, last_kept, capacity_overflow
//   cfg      input      cfg_valid/cfg_ready cfg_data = overlap_threshold
//
// Boxes load one per cycle while in_stall is low. Closing a set of n boxes with k
// survivors takes a pick-up step for the set, then k+1 scan passes (n store
// reads, a drain of the pipe, one emit step each); each pass walks the box
// store through its single read port.
// Input stalls from the cycle after last_box until the last survivor sits in
// the output register. A stalled output holds the scan at the end of a pass.
// Reset clears the live marks at once; no clearing pass follows reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module greedy_box_suppression_unit #(
  parameter int MAX_BOXES  = gbs_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF,
  parameter int SCORE_BITS = gbs_pkg::SCORE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [COORD_BITS-1:0]            box_left,
  input  wire logic [COORD_BITS-1:0]            box_top,
  input  wire logic [COORD_BITS-1:0]            box_width,
  input  wire logic [COORD_BITS-1:0]            box_height,
  input  wire logic [SCORE_BITS-1:0]            box_score,
  input  wire logic [gbs_pkg::CLASS_BITS-1:0]   box_class,
  input  wire logic                             last_box,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [COORD_BITS-1:0]                 kept_left,
  output logic [COORD_BITS-1:0]                 kept_top,
  output logic [COORD_BITS-1:0]                 kept_width,
  output logic [COORD_BITS-1:0]                 kept_height,
  output logic [SCORE_BITS-1:0]                 kept_score,
  output logic [gbs_pkg::CLASS_BITS-1:0]        kept_class,
  output logic                                  last_kept,
  output logic                                  capacity_overflow,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [gbs_pkg::THRESH_BITS-1:0]  cfg_data
);

  import gbs_pkg::*;

  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int C  = COORD_BITS;
  localparam int EW = 4 * C + SCORE_BITS + CLASS_BITS;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          push;
  logic [CW-1:0] push_count;
  logic          push_ovf;
  logic [CW:0]   job_data;
  logic          job_empty;
  logic          job_pop;
  logic          busy;
  logic [EW-1:0] out_entry;

  gbs_loader #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS),
    .SCORE_BITS (SCORE_BITS)
  ) u_loader (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .last_box     (last_box),
    .hold         (busy || !job_empty),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .job_push     (push),
    .job_count    (push_count),
    .job_overflow (push_ovf)
  );

  gbs_job_fifo #(
    .WIDTH (CW + 1)
  ) u_jobs (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ovf, push_count}),
    .pop       (job_pop),
    .pop_data  (job_data),
    .empty     (job_empty)
  );

  gbs_engine #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS),
    .SCORE_BITS (SCORE_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      ({box_left, box_top, box_width, box_height, box_score, box_class}),
    .job_ready    (!job_empty),
    .job_count    (job_data[CW-1:0]),
    .job_overflow (job_data[CW]),
    .job_pop      (job_pop),
    .busy         (busy),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_entry    (out_entry),
    .out_last     (last_kept),
    .out_overflow (capacity_overflow)
  );

  assign kept_class  = out_entry[CLASS_BITS-1:0];
  assign kept_score  = out_entry[CLASS_BITS +: SCORE_BITS];
  assign kept_height = out_entry[CLASS_BITS + SCORE_BITS +: C];
  assign kept_width  = out_entry[CLASS_BITS + SCORE_BITS + C +: C];
  assign kept_top    = out_entry[CLASS_BITS + SCORE_BITS + 2 * C +: C];
  assign kept_left   = out_entry[CLASS_BITS + SCORE_BITS + 3 * C +: C];

endmodule

`default_nettype wire

// ===== rtl/gbs_job_fifo.sv =====
// ----------------------------------------------------------------------------
// gbs_job_fifo
// Two-entry queue of closed sets (box count and overflow flag).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbs_job_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wp;
  logic             rp;
  logic [1:0]       fill;

  assign empty    = (fill == 2'd0);
  assign pop_data = slots[rp];

  always_ff @(posedge clk) begin
    if (push && fill != 2'd2) begin
      slots[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && fill != 2'd2) begin
        wp <= ~wp;
      end
      if (pop && !empty) begin
        rp <= ~rp;
      end
      case ({push && fill != 2'd2, pop && !empty})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gbs_loader.sv =====
// ----------------------------------------------------------------------------
// gbs_loader
// Front end: takes boxes, writes them to the store, closes sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbs_loader #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 12,
  parameter int SCORE_BITS = 16,
  localparam int AW = $clog2(MAX_BOXES),
  localparam int CW = $clog2(MAX_BOXES + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  last_box,
  input  wire logic                  hold,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic                       job_push,
  output logic [CW-1:0]              job_count,
  output logic                       job_overflow
);

  import gbs_pkg::*;

  logic          accept;
  logic          room;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          overflow;
  logic          overflow_next;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;
  assign room     = (count < CW'(MAX_BOXES));
  assign wr_en    = accept && room;
  assign wr_addr  = count[AW-1:0];

  assign count_next    = room ? count + CW'(1) : count;
  assign overflow_next = overflow || !room;

  assign job_push     = accept && last_box;
  assign job_count    = count_next;
  assign job_overflow = overflow_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (accept) begin
      if (last_box) begin
        count    <= '0;
        overflow <= 1'b0;
      end else begin
        count    <= count_next;
        overflow <= overflow_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gbs_engine.sv =====
// ----------------------------------------------------------------------------
// gbs_engine
// Back end: box store, scan passes that pick the best live box and drop
// every live box that overlaps the current winner too much.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbs_engine #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 12,
  parameter int SCORE_BITS = 16,
  localparam int AW = $clog2(MAX_BOXES),
  localparam int CW = $clog2(MAX_BOXES + 1),
  localparam int EW = 4 * COORD_BITS + SCORE_BITS + gbs_pkg::CLASS_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [AW-1:0]                    wr_addr,
  input  wire logic [EW-1:0]                    wr_data,
  input  wire logic                             job_ready,
  input  wire logic [CW-1:0]                    job_count,
  input  wire logic                             job_overflow,
  output logic                                  job_pop,
  output logic                                  busy,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [gbs_pkg::THRESH_BITS-1:0]  cfg_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [EW-1:0]                         out_entry,
  output logic                                  out_last,
  output logic                                  out_overflow
);

  import gbs_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int OFS_SC = CLASS_BITS;
  localparam int OFS_H  = OFS_SC + SCORE_BITS;
  localparam int OFS_W  = OFS_H + C;
  localparam int OFS_T  = OFS_W + C;
  localparam int OFS_L  = OFS_T + C;
  localparam int AR     = 2 * C;
  localparam int IW     = 2 * C + 2;
  localparam int LW     = IW + FRAC_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PASS = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [EW-1:0]          store [MAX_BOXES];
  logic [EW-1:0]          rd_q;
  logic [MAX_BOXES-1:0]   alive;
  logic [THRESH_BITS-1:0] thr;

  logic [1:0]    state;
  logic [CW-1:0] n;
  logic          ovf;
  logic [CW-1:0] iss;
  logic          have_win;
  logic [EW-1:0] win;
  logic [AR-1:0] win_area;
  logic          found;
  logic [EW-1:0] best;
  logic [AW-1:0] best_idx;
  logic [AR-1:0] best_area;

  // scan pipeline
  logic          v0, v1, v2, v3, v4;
  logic [AW-1:0] idx0, idx1, idx2, idx3, idx4;
  logic [EW-1:0] e1, e2, e3, e4;
  logic [C-1:0]  x1, y1;
  logic [C:0]    x2, y2;
  logic [AR-1:0] ab1, ab2, ab3, ab4;
  logic [IW-1:0] inter2, inter3, uni3;
  logic [LW-1:0] lhs4, prod4;

  // stage combinational terms
  logic [C-1:0]  al, at, aw, ah, bl, bt, bw, bh;
  logic [C:0]    ar, ab_r, abt, bb;
  logic [C:0]    wi, hi;
  logic          over;
  logic          can_out;
  logic          pass_done;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign job_pop   = (state == S_IDLE) && job_ready;
  assign can_out   = !out_valid || !out_stall;
  assign pass_done = (iss == n) && !v0 && !v1 && !v2 && !v3 && !v4;

  assign al = win[OFS_L +: C];
  assign at = win[OFS_T +: C];
  assign aw = win[OFS_W +: C];
  assign ah = win[OFS_H +: C];
  assign bl = rd_q[OFS_L +: C];
  assign bt = rd_q[OFS_T +: C];
  assign bw = rd_q[OFS_W +: C];
  assign bh = rd_q[OFS_H +: C];
  assign ar   = {1'b0, al} + {1'b0, aw};
  assign ab_r = {1'b0, bl} + {1'b0, bw};
  assign abt  = {1'b0, at} + {1'b0, ah};
  assign bb   = {1'b0, bt} + {1'b0, bh};

  assign wi = (x2 > {1'b0, x1}) ? x2 - {1'b0, x1} : '0;
  assign hi = (y2 > {1'b0, y1}) ? y2 - {1'b0, y1} : '0;

  assign over = have_win && (lhs4 > prod4);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_q <= store[iss[AW-1:0]];
  end

  // datapath stages
  always_ff @(posedge clk) begin
    idx1   <= idx0;
    e1     <= rd_q;
    x1     <= (al > bl) ? al : bl;
    y1     <= (at > bt) ? at : bt;
    x2     <= (ar < ab_r) ? ar : ab_r;
    y2     <= (abt < bb) ? abt : bb;
    ab1    <= {{C{1'b0}}, bw} * {{C{1'b0}}, bh};

    idx2   <= idx1;
    e2     <= e1;
    ab2    <= ab1;
    inter2 <= {{(C + 1){1'b0}}, wi} * {{(C + 1){1'b0}}, hi};

    idx3   <= idx2;
    e3     <= e2;
    ab3    <= ab2;
    inter3 <= inter2;
    uni3   <= {2'b00, win_area} + {2'b00, ab2} - inter2;

    idx4   <= idx3;
    e4     <= e3;
    ab4    <= ab3;
    lhs4   <= {inter3, {FRAC_BITS{1'b0}}};
    prod4  <= {{IW{1'b0}}, thr} * {{FRAC_BITS{1'b0}}, uni3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THRESH_RESET;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      alive     <= '0;
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      have_win  <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
      iss       <= '0;
      n         <= '0;
      ovf       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        alive[wr_addr] <= 1'b1;
      end

      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;

      // resolve one scanned entry: drop it, or weigh it as next winner
      if (v4 && alive[idx4]) begin
        if (over) begin
          alive[idx4] <= 1'b0;
        end else if (!found || e4[OFS_SC +: SCORE_BITS] > best[OFS_SC +: SCORE_BITS]) begin
          found     <= 1'b1;
          best      <= e4;
          best_idx  <= idx4;
          best_area <= ab4;
        end
      end

      unique case (state)
        S_IDLE: begin
          v0 <= 1'b0;
          if (job_ready) begin
            n        <= job_count;
            ovf      <= job_overflow;
            have_win <= 1'b0;
            found    <= 1'b0;
            iss      <= '0;
            state    <= S_PASS;
          end
        end
        S_PASS: begin
          if (iss != n) begin
            v0   <= 1'b1;
            idx0 <= iss[AW-1:0];
            iss  <= iss + CW'(1);
          end else begin
            v0 <= 1'b0;
            if (pass_done) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          v0 <= 1'b0;
          if (!have_win || can_out) begin
            if (have_win) begin
              out_valid    <= 1'b1;
              out_entry    <= win;
              out_last     <= !found;
              out_overflow <= ovf;
            end
            if (found) begin
              win             <= best;
              win_area        <= best_area;
              have_win        <= 1'b1;
              alive[best_idx] <= 1'b0;
              found           <= 1'b0;
              iss             <= '0;
              state           <= S_PASS;
            end else begin
              have_win <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
